// ===== hw/rtl/mwl_pkg.sv =====
// Shared types, constants and table functions for the multi-waveform oscillator.
package mwl_pkg;

  localparam int unsigned PHASE_BITS_DEF   = 32;
  localparam int unsigned SINE_ENTRIES_DEF = 256;
  localparam int unsigned OUT_BITS_DEF     = 16;

  // Raw waveform samples span -32768 to +32768, which needs 17 signed bits.
  localparam int unsigned WAVE_BITS  = 17;
  localparam int unsigned RAND_BITS  = 16;
  localparam int unsigned DEPTH_BITS = 16;
  localparam int unsigned STEP_BITS  = 32;
  localparam int unsigned LFSR_BITS  = 32;
  localparam int unsigned LFSR_SHIFTS = 16;

  localparam logic [LFSR_BITS-1:0] LFSR_SEED = 32'hACE1_ACE1;
  localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1073741824;

  typedef enum logic [1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_WAVEFORM   = 2'd1,
    CFG_DEPTH      = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_SAW      = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_RANDOM   = 3'd4
  } wave_e;

  // Quarter-wave sine entry in Q1.15, from a fixed-point Taylor series at elaboration.
  function automatic logic [WAVE_BITS-1:0] sine_value(input int idx, input int ebits);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint v;
    x    = (HALF_PI_Q30 * longint'(idx)) >>> ebits;
    x2   = x * x / Q30_ONE;
    term = x;
    sum  = x;
    // Twelve further terms; term k is divided by (2k)(2k+1).
    term = -(term * x2 / Q30_ONE) / 64'sd6;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd20;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd42;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd72;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd110;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd156;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd210;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd272;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd342;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd420;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd506;
    sum  = sum + term;
    term = -(term * x2 / Q30_ONE) / 64'sd600;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd16384) / 64'sd32768;
    if (v > 64'sd32768) begin
      v = 64'sd32768;
    end
    return v[WAVE_BITS-1:0];
  endfunction

  // Sixteen Galois shifts; being linear, this reduces to a fixed XOR network per bit.
  function automatic logic [LFSR_BITS-1:0] lfsr_advance(input logic [LFSR_BITS-1:0] s);
    logic [LFSR_BITS-1:0] r;
    r = s;
    for (int n = 0; n < LFSR_SHIFTS; n++) begin
      r = r[0] ? ((r >> 1) ^ LFSR_TAPS) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mwl_phase.sv =====
// Phase accumulator, random-hold generator and input register of the oscillator.
module mwl_phase #(
  parameter int unsigned PHASE_BITS = mwl_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_tick_i,
  output logic                            in_ready_o,
  input  logic [mwl_pkg::STEP_BITS-1:0]   phase_step_i,
  input  logic [2:0]                      waveform_i,
  input  logic [mwl_pkg::DEPTH_BITS-1:0]  depth_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [PHASE_BITS-1:0]           out_phase_o,
  output logic [mwl_pkg::RAND_BITS-1:0]   out_held_o
);

  logic [PHASE_BITS-1:0]         phase_q, phase_d;
  logic [mwl_pkg::RAND_BITS-1:0] held_q, held_d;
  logic [mwl_pkg::LFSR_BITS-1:0] lfsr_q, lfsr_d;
  logic [mwl_pkg::LFSR_BITS-1:0] lfsr_next;
  logic                          valid_q;
  logic [PHASE_BITS-1:0]         s1_phase_q;
  logic [mwl_pkg::RAND_BITS-1:0] s1_held_q;
  logic [PHASE_BITS-1:0]         step_w;
  logic [PHASE_BITS:0]           sum_w;
  logic                          take;
  logic                          advance;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o && in_tick_i;
  assign advance    = take && (depth_i != '0);

  assign step_w    = PHASE_BITS'(phase_step_i);
  assign sum_w     = {1'b0, phase_q} + {1'b0, step_w};
  assign lfsr_next = mwl_pkg::lfsr_advance(lfsr_q);

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    lfsr_d  = lfsr_q;
    if (advance) begin
      phase_d = sum_w[PHASE_BITS-1:0];
      // The held value is redrawn only when the phase wraps in random mode.
      if (sum_w[PHASE_BITS] && (waveform_i == mwl_pkg::WAVE_RANDOM)) begin
        lfsr_d = lfsr_next;
        held_d = lfsr_next[mwl_pkg::RAND_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
      lfsr_q  <= mwl_pkg::LFSR_SEED;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      lfsr_q  <= lfsr_d;
      if (in_ready_o) begin
        valid_q <= take;
      end
    end
  end

  // The sample uses the state as it stood before this request.
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_phase_q <= phase_q;
      s1_held_q  <= held_q;
    end
  end

  assign out_valid_o = valid_q;
  assign out_phase_o = s1_phase_q;
  assign out_held_o  = s1_held_q;

endmodule

// ===== hw/rtl/mwl_shape.sv =====
// Waveform shaping from the registered phase: sine table, square, saw, triangle, hold.
module mwl_shape #(
  parameter int unsigned PHASE_BITS         = mwl_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_ENTRIES = mwl_pkg::SINE_ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [PHASE_BITS-1:0]                in_phase_i,
  input  logic [mwl_pkg::RAND_BITS-1:0]        in_held_i,
  input  logic [2:0]                           waveform_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mwl_pkg::WAVE_BITS-1:0] out_wave_o
);

  localparam int unsigned EntryBits = $clog2(SINE_TABLE_ENTRIES);
  localparam int unsigned RomIdxW   = EntryBits + 1;
  localparam int unsigned WB        = mwl_pkg::WAVE_BITS;

  logic [WB-1:0]          sine_rom [SINE_TABLE_ENTRIES+1];
  logic [1:0]             quadrant;
  logic [EntryBits-1:0]   idx;
  logic [RomIdxW-1:0]     rom_idx;
  logic [WB-1:0]          mag;
  logic [15:0]            top16;
  logic signed [WB-1:0]   saw;
  logic [WB-1:0]          saw_mag;
  logic signed [WB:0]     tri_full;
  logic signed [WB-1:0]   wave_d;
  logic signed [WB-1:0]   wave_q;
  logic                   valid_q;

  for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_rom
    assign sine_rom[g] = mwl_pkg::sine_value(g, EntryBits);
  end

  assign quadrant = in_phase_i[PHASE_BITS-1 -: 2];
  assign idx      = in_phase_i[PHASE_BITS-3 -: EntryBits];
  // Odd quadrants read the quarter wave backwards.
  assign rom_idx  = quadrant[0] ? (RomIdxW'(SINE_TABLE_ENTRIES) - {1'b0, idx})
                                : {1'b0, idx};
  assign mag      = sine_rom[rom_idx];

  assign top16    = in_phase_i[PHASE_BITS-1 -: 16];
  assign saw      = $signed({~top16[15], ~top16[15], top16[14:0]});
  assign saw_mag  = saw[WB-1] ? WB'(-saw) : WB'(saw);
  assign tri_full = $signed({saw_mag, 1'b0}) - (WB+1)'(32768);

  always_comb begin
    case (mwl_pkg::wave_e'(waveform_i))
      mwl_pkg::WAVE_SINE:     wave_d = quadrant[1] ? -$signed(mag) : $signed(mag);
      mwl_pkg::WAVE_SQUARE:   wave_d = quadrant[1] ? -WB'(32768) : WB'(32768);
      mwl_pkg::WAVE_SAW:      wave_d = saw;
      mwl_pkg::WAVE_TRIANGLE: wave_d = tri_full[WB-1:0];
      mwl_pkg::WAVE_RANDOM:   wave_d = {in_held_i[15], in_held_i};
      default:                wave_d = '0;
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      wave_q <= wave_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_wave_o  = wave_q;

endmodule

// ===== hw/rtl/mwl_scale.sv =====
// Depth scaling with rounding and saturation, feeding the output register.
module mwl_scale #(
  parameter int unsigned OUT_BITS = mwl_pkg::OUT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [mwl_pkg::WAVE_BITS-1:0] in_wave_i,
  input  logic [mwl_pkg::DEPTH_BITS-1:0]       depth_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [OUT_BITS-1:0]                  out_value_o
);

  localparam int unsigned ProdBits = mwl_pkg::WAVE_BITS + mwl_pkg::DEPTH_BITS + 1;
  localparam int unsigned SumBits  = ProdBits + 1;
  localparam int unsigned Shift    = 31 - OUT_BITS;
  localparam longint      SatHi    = (longint'(1) << (OUT_BITS - 1)) - 1;
  localparam longint      SatLo    = -(longint'(1) << (OUT_BITS - 1));

  logic signed [ProdBits-1:0] prod;
  logic signed [SumBits-1:0]  rounded;
  logic signed [SumBits-1:0]  scaled;
  logic [OUT_BITS-1:0]        value_d;
  logic [OUT_BITS-1:0]        value_q;
  logic                       valid_q;

  assign prod    = in_wave_i * $signed({1'b0, depth_i});
  assign rounded = SumBits'(prod) + SumBits'(longint'(1) << (Shift - 1));
  assign scaled  = rounded >>> Shift;

  always_comb begin
    if (longint'(scaled) > SatHi) begin
      value_d = SatHi[OUT_BITS-1:0];
    end else if (longint'(scaled) < SatLo) begin
      value_d = SatLo[OUT_BITS-1:0];
    end else begin
      value_d = scaled[OUT_BITS-1:0];
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_value_o = value_q;

endmodule

// ===== hw/rtl/multi_waveform_lfo.sv =====
// Multi-waveform low-frequency oscillator driven by sample ticks.
//
// Usage: software writes phase_step, waveform and depth over the configuration channel
// (index 0, 1, 2) while the block is idle. Each request on the slave stream whose tick
// bit is set yields one signed sample on the master stream; a request with tick clear
// is taken and dropped without changing any state.
// A request's sample passes three registers, phase, waveform and scaled output, on its way
// from the edge that takes the request to m_axis_tvalid.
// Throughput: one request per cycle while the output stream does not stall, as each request
// updates the phase accumulator before the next can use the new phase.
// The pipeline has three registered stages (phase, waveform, scaled output); each stage
// accepts new data whenever it is empty or its successor takes its content, so a
// stalled receiver fills the stages one by one and only then drops s_axis_tready.
// Reset clears the phase and the held random value, seeds the noise generator and
// clears all configuration registers, so depth is zero after reset and every sample
// is zero until depth is written.
// The configuration channel is always ready; writes to an index beyond depth are ignored.
module multi_waveform_lfo #(
  parameter int unsigned PHASE_BITS         = mwl_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_ENTRIES = mwl_pkg::SINE_ENTRIES_DEF,
  parameter int unsigned OUT_BITS           = mwl_pkg::OUT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [0] tick, rest zero
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [((OUT_BITS+7)/8)*8-1:0]   m_axis_tdata,   // [OUT_BITS-1:0] lfo_value
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [mwl_pkg::STEP_BITS-1:0]   cfg_data_i
);

  localparam int unsigned TdataBits = ((OUT_BITS + 7) / 8) * 8;

  logic [mwl_pkg::STEP_BITS-1:0]         phase_step_q;
  logic [2:0]                            waveform_q;
  logic [mwl_pkg::DEPTH_BITS-1:0]        depth_q;

  logic                                  s1_valid;
  logic                                  s1_ready;
  logic [PHASE_BITS-1:0]                 s1_phase;
  logic [mwl_pkg::RAND_BITS-1:0]         s1_held;
  logic                                  s2_valid;
  logic                                  s2_ready;
  logic signed [mwl_pkg::WAVE_BITS-1:0]  s2_wave;
  logic [OUT_BITS-1:0]                   out_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      waveform_q   <= '0;
      depth_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mwl_pkg::cfg_reg_e'(cfg_index_i))
        mwl_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
        mwl_pkg::CFG_WAVEFORM:   waveform_q   <= cfg_data_i[2:0];
        mwl_pkg::CFG_DEPTH:      depth_q      <= cfg_data_i[mwl_pkg::DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  mwl_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_tick_i    (s_axis_tdata[0]),
    .in_ready_o   (s_axis_tready),
    .phase_step_i (phase_step_q),
    .waveform_i   (waveform_q),
    .depth_i      (depth_q),
    .out_valid_o  (s1_valid),
    .out_ready_i  (s1_ready),
    .out_phase_o  (s1_phase),
    .out_held_o   (s1_held)
  );

  mwl_shape #(
    .PHASE_BITS         (PHASE_BITS),
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_phase_i  (s1_phase),
    .in_held_i   (s1_held),
    .waveform_i  (waveform_q),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_wave_o  (s2_wave)
  );

  mwl_scale #(
    .OUT_BITS (OUT_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_wave_i   (s2_wave),
    .depth_i     (depth_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value)
  );

  assign m_axis_tdata = TdataBits'(out_value);

`ifndef NO_ASSERTIONS
  // Input back-pressure only arises once every stage holds a sample.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid && s2_valid && m_axis_tvalid))
    else $error("input stalled while a pipeline stage was empty");

  // A taken tick request always lands in the first stage.
  a_tick_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) |=> s1_valid)
    else $error("tick request lost at the first stage");

  // Raw waveform samples stay within plus and minus one.
  a_wave_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid |-> ((s2_wave >= -18'sd32768) && (s2_wave <= 18'sd32768)))
    else $error("waveform sample out of range");
`endif

endmodule
